[design/psl_pkg.sv]
// Shared types and codes for the positional insert/delete/search list.
// No dependencies; compile first.
package psl_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 7;

  typedef logic [POS_W-1:0]         pos_t;
  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_DUMP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_DELETED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_BADPOS   = 3'd4,
    ST_FOUND    = 3'd5,
    ST_NOTFOUND = 3'd6,
    ST_ENTRY    = 3'd7
  } status_t;

  // Broadcast operation applied by every cell in the same cycle.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_MARK,
    OP_CLEAR,
    OP_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    pos_t     pos;    // 0-based target position or upper bound
    data_t    value;  // insert value or search key
  } cell_ctl_t;

endpackage

[design/psl_req_if.sv]
// Request channel: valid/ready handshake carrying one command item.
// Depends on psl_pkg.
interface psl_req_if;
  import psl_pkg::*;

  logic  valid;
  logic  ready;
  cmd_t  cmd;
  data_t value;
  pos_t  slot;

  modport source (output valid, cmd, value, slot, input ready);
  modport sink   (input valid, cmd, value, slot, output ready);
endinterface

[design/psl_rsp_if.sv]
// Response channel: valid/ready handshake carrying one result item.
// Depends on psl_pkg.
interface psl_rsp_if;
  import psl_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  data_t   data;
  pos_t    where;
  pos_t    fill;
  logic    last;

  modport source (output valid, status, data, where, fill, last, input ready);
  modport sink   (input valid, status, data, where, fill, last, output ready);
endinterface

[design/psl_cell.sv]
// One list cell: holds a single entry and its match flag, shifts with neighbors.
// Depends on psl_pkg.
module psl_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  psl_pkg::cell_ctl_t ctl,
  input  psl_pkg::data_t    prev_entry,
  input  psl_pkg::data_t    next_entry,
  input  psl_pkg::data_t    wrap_entry,
  output psl_pkg::data_t    entry,
  output logic              flag
);
  import psl_pkg::*;

  localparam pos_t MY_POS = pos_t'(IDX);

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_INSERT: begin
        if (MY_POS > ctl.pos) begin
          entry <= prev_entry;
        end else if (MY_POS == ctl.pos) begin
          entry <= ctl.value;
        end
      end
      OP_DELETE: begin
        if (MY_POS >= ctl.pos) begin
          entry <= next_entry;
        end
      end
      OP_ROTATE: begin
        // pos is the last occupied cell; it takes the head entry
        if (MY_POS == ctl.pos) begin
          entry <= wrap_entry;
        end else if (MY_POS < ctl.pos) begin
          entry <= next_entry;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else begin
      case (ctl.op)
        OP_MARK:  flag <= (MY_POS <= ctl.pos) && (entry == ctl.value);
        OP_CLEAR: if (MY_POS == ctl.pos) flag <= 1'b0;
        default:  ;
      endcase
    end
  end

endmodule

[design/positional_insert_delete_search_list.sv]
// Positional insert/delete/search list: top level, cell chain and sequencer.
// Depends on psl_pkg, psl_req_if, psl_rsp_if, psl_cell.
//
// An ordered list of up to DEPTH signed 32-bit entries kept in a row of
// cells. Insert and delete shift every later cell by one in the accept
// cycle, and each gives one result item. Search compares all cells in
// parallel in the accept cycle, then emits one found item per matching
// position in ascending order, lowest flag first (or one not-found item).
// Dump rotates the occupied cells toward the head, reading one entry per
// cycle at the head cell while the result register is free, and after
// fill rotations the list is back in its original order. Empty list
// search/dump gives a single empty item. One command item is worked on
// at a time; a new item is taken once the sequencer is idle and the result
// register is free or being drained. No clearing pass after reset: the
// fill count alone decides which cells hold live entries.
module positional_insert_delete_search_list #(
  parameter int unsigned DEPTH = 64
) (
  input logic      clk,
  input logic      rst,
  psl_req_if.sink  req,
  psl_rsp_if.source rsp
);
  import psl_pkg::*;

  localparam pos_t DEPTH_POS = pos_t'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DUMP
  } state_t;

  state_t    state, state_next;
  pos_t      count, count_next;
  pos_t      cursor, cursor_next;
  cell_ctl_t ctl;

  data_t            entry_vec [DEPTH];
  logic [DEPTH-1:0] flag_vec;
  logic [DEPTH-1:0] lowest;
  logic [DEPTH-1:0] rest;
  pos_t             pick;

  logic    in_acc, out_free;
  logic    ins_ok, del_ok;
  logic    o_load, o_last;
  status_t o_status;
  data_t   o_data;
  pos_t    o_where;

  // Cell chain: each cell sees its neighbors and the head entry.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    data_t prev_e, next_e;
    if (i == 0) begin : g_head
      assign prev_e = ctl.value;
    end else begin : g_prev
      assign prev_e = entry_vec[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_e = entry_vec[i];
    end else begin : g_next
      assign next_e = entry_vec[i+1];
    end
    psl_cell #(.IDX(i)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .wrap_entry (entry_vec[0]),
      .entry      (entry_vec[i]),
      .flag       (flag_vec[i])
    );
  end

  // Lowest pending match and what remains after it.
  assign lowest = flag_vec & (~flag_vec + {{(DEPTH-1){1'b0}}, 1'b1});
  assign rest   = flag_vec & ~lowest;

  always_comb begin
    pick = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (lowest[i]) pick = pick | pos_t'(i);
    end
  end

  assign in_acc   = req.valid && req.ready;
  assign out_free = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;

  // slot is 1-based; insert may append right after the last entry
  assign ins_ok = (req.slot != '0) && ((req.slot - pos_t'(1)) <= count);
  assign del_ok = (req.slot != '0) && (req.slot <= count);

  always_comb begin
    ctl         = '{op: OP_HOLD, pos: '0, value: req.value};
    state_next  = state;
    count_next  = count;
    cursor_next = cursor;
    o_load      = 1'b0;
    o_status    = ST_INSERTED;
    o_data      = '0;
    o_where     = '0;
    o_last      = 1'b1;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          o_load = 1'b1;
          case (req.cmd)
            CMD_INSERT: begin
              if (count >= DEPTH_POS) begin
                o_status = ST_FULL;
              end else if (!ins_ok) begin
                o_status = ST_BADPOS;
              end else begin
                ctl.op     = OP_INSERT;
                ctl.pos    = req.slot - pos_t'(1);
                count_next = count + pos_t'(1);
                o_status   = ST_INSERTED;
              end
            end
            CMD_DELETE: begin
              if (count == '0) begin
                o_status = ST_EMPTY;
              end else if (!del_ok) begin
                o_status = ST_BADPOS;
              end else begin
                ctl.op     = OP_DELETE;
                ctl.pos    = req.slot - pos_t'(1);
                count_next = count - pos_t'(1);
                o_status   = ST_DELETED;
              end
            end
            CMD_SEARCH: begin
              if (count == '0) begin
                o_status = ST_EMPTY;
              end else begin
                o_load     = 1'b0;
                ctl.op     = OP_MARK;
                ctl.pos    = count - pos_t'(1);
                state_next = S_SEARCH;
              end
            end
            default: begin
              if (count == '0) begin
                o_status = ST_EMPTY;
              end else begin
                o_load      = 1'b0;
                cursor_next = '0;
                state_next  = S_DUMP;
              end
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (out_free) begin
          o_load = 1'b1;
          if (flag_vec == '0) begin
            o_status   = ST_NOTFOUND;
            state_next = S_IDLE;
          end else begin
            o_status = ST_FOUND;
            o_where  = pick + pos_t'(1);
            o_last   = (rest == '0);
            ctl.op   = OP_CLEAR;
            ctl.pos  = pick;
            if (rest == '0) state_next = S_IDLE;
          end
        end
      end
      S_DUMP: begin
        if (out_free) begin
          o_load      = 1'b1;
          o_status    = ST_ENTRY;
          o_data      = entry_vec[0];
          o_where     = cursor + pos_t'(1);
          o_last      = (cursor + pos_t'(1)) == count;
          ctl.op      = OP_ROTATE;
          ctl.pos     = count - pos_t'(1);
          cursor_next = cursor + pos_t'(1);
          if (o_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cursor    <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      cursor <= cursor_next;
      if (o_load) begin
        rsp.valid  <= 1'b1;
        rsp.status <= o_status;
        rsp.data   <= o_data;
        rsp.where  <= o_where;
        rsp.fill   <= count_next;
        rsp.last   <= o_last;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Fill count never passes the cell count.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_POS)
    else $error("fill count above depth");

  // Dump cursor stays inside the occupied cells.
  a_dump_cursor: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP) |-> (cursor < count))
    else $error("dump cursor past fill");

  // A good insert grows the list by exactly one.
  a_insert_grow: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (req.cmd == CMD_INSERT) && (count < DEPTH_POS) && ins_ok)
      |=> (count == $past(count) + pos_t'(1)))
    else $error("insert did not grow list");

  // A non-final result means the sequencer is still busy with that command.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.last) |-> (state != S_IDLE))
    else $error("sequencer idle before final item");

endmodule

[sim/positional_insert_delete_search_list_test.sv]
// Self-checking testbench for the positional insert/delete/search list.
// Depends on psl_pkg, psl_req_if, psl_rsp_if and positional_insert_delete_search_list.
// Drives command items, predicts every result item and compares field by field.
module positional_insert_delete_search_list_test;
  timeunit 1ns;
  timeprecision 1ps;

  import psl_pkg::*;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned WATCHDOG   = 2000;  // cycles with no item moving on either side
  localparam int unsigned BACKLOG    = 400;   // long receiver hold-off, in cycles
  localparam int unsigned TAIL       = 100;   // quiet cycles after the last expected item
  localparam int unsigned RAND_ITEMS = 200;   // random items, not counting fill and drain runs

  // One command item waiting to be offered, with the idle cycles ahead of it.
  typedef struct {
    cmd_t        cmd;
    data_t       value;
    pos_t        slot;
    int unsigned gap;
  } command_t;

  // One result item as the block should produce it.
  typedef struct {
    status_t status;
    data_t   data;
    pos_t    where;
    pos_t    fill;
    logic    last;
  } result_t;

  logic clk = 1'b0;
  logic rst;

  psl_req_if req ();
  psl_rsp_if rsp ();

  positional_insert_delete_search_list #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #6 clk = ~clk;

  // Commands not yet offered, and result items not yet seen.
  command_t    command_q[$];
  result_t     expected_q[$];

  // Shadow copy of the list, advanced as each command item is accepted.
  data_t       shadow_list[DEPTH];
  int unsigned shadow_len = 0;

  // Length the list will have once everything queued so far has run;
  // lets the stimulus aim at valid positions.
  int unsigned plan_len = 0;
  bit          quiet    = 1'b0;  // no idle cycles for items queued while set
  data_t       key_pool[6];      // small value set so searches hit several positions

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned gap_waited = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          backlog_done = 1'b0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // The fill field always reports the length after the command has taken effect.
  task automatic post_result(status_t st, data_t d, int unsigned pos, logic fin);
    result_t r;
    r.status = st;
    r.data   = d;
    r.where  = pos_t'(pos);
    r.fill   = pos_t'(shadow_len);
    r.last   = fin;
    expected_q.push_back(r);
  endtask

  task automatic run_list_command(cmd_t c, data_t v, pos_t s);
    int          i;
    int unsigned hits[$];
    case (c)
      CMD_INSERT: begin
        // full takes priority over a bad position
        if (shadow_len >= DEPTH) begin
          post_result(ST_FULL, '0, 0, 1'b1);
        end else if (s == 0 || s > shadow_len + 1) begin
          post_result(ST_BADPOS, '0, 0, 1'b1);
        end else begin
          for (i = int'(shadow_len); i >= int'(s); i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[s-1] = v;
          shadow_len++;
          post_result(ST_INSERTED, '0, 0, 1'b1);
        end
      end
      CMD_DELETE: begin
        // empty takes priority over a bad position
        if (shadow_len == 0) begin
          post_result(ST_EMPTY, '0, 0, 1'b1);
        end else if (s == 0 || s > shadow_len) begin
          post_result(ST_BADPOS, '0, 0, 1'b1);
        end else begin
          for (i = int'(s) - 1; i + 1 < int'(shadow_len); i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
          post_result(ST_DELETED, '0, 0, 1'b1);
        end
      end
      CMD_SEARCH: begin
        if (shadow_len == 0) begin
          post_result(ST_EMPTY, '0, 0, 1'b1);
        end else begin
          for (i = 0; i < int'(shadow_len); i++)
            if (shadow_list[i] == v) hits.push_back(i + 1);
          if (hits.size() == 0) begin
            post_result(ST_NOTFOUND, '0, 0, 1'b1);
          end else begin
            // one found item per match, ascending, last flag on the final one
            for (i = 0; i < hits.size(); i++)
              post_result(ST_FOUND, '0, hits[i], i == hits.size() - 1);
          end
        end
      end
      default: begin
        if (shadow_len == 0) begin
          post_result(ST_EMPTY, '0, 0, 1'b1);
        end else begin
          for (i = 0; i < int'(shadow_len); i++)
            post_result(ST_ENTRY, shadow_list[i], i + 1, i + 1 == int'(shadow_len));
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_command(cmd_t c, data_t v, pos_t s);
    command_t q;
    q.cmd   = c;
    q.value = v;
    q.slot  = s;
    q.gap   = quiet ? 0 : $urandom_range(0, 11);
    command_q.push_back(q);
    if (c == CMD_INSERT && plan_len < DEPTH && s >= 1 && s <= plan_len + 1)
      plan_len++;
    else if (c == CMD_DELETE && s >= 1 && s <= plan_len)
      plan_len--;
  endtask

  // Mostly pool values so duplicates pile up; the rest fully random.
  function automatic data_t pick_value();
    if ($urandom_range(0, 9) < 6) return key_pool[$urandom_range(0, 5)];
    return data_t'($urandom);
  endfunction

  function automatic pos_t live_slot(int unsigned hi);
    return pos_t'($urandom_range(1, hi));
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued command items, honoring each item's idle gap.
  // The prediction runs at the edge where an item is accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_commands
    command_t nxt;
    if (rst) begin
      req.valid <= 1'b0;
      gap_waited = 0;
    end else begin
      if (req.valid && req.ready) run_list_command(req.cmd, req.value, req.slot);
      if (!req.valid || req.ready) begin
        if (command_q.size() == 0) begin
          req.valid <= 1'b0;
        end else if (gap_waited < command_q[0].gap) begin
          gap_waited++;
          req.valid <= 1'b0;
        end else begin
          nxt = command_q.pop_front();
          gap_waited = 0;
          req.valid <= 1'b1;
          req.cmd   <= nxt.cmd;
          req.value <= nxt.value;
          req.slot  <= nxt.slot;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result item against the oldest expectation and
  // throttles ready. After 80 result items it holds ready low for a long
  // stretch so the result path backs up and the block refuses commands.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
    if (seen !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("result item with none expected: status %0d where %0d",
                 rsp.status, rsp.where);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", want.status, rsp.status);
          check_field("data",   want.data,   rsp.data);
          check_field("where",  want.where,  rsp.where);
          check_field("fill",   want.fill,   rsp.fill);
          check_field("last",   want.last,   rsp.last);
        end
        // every third window of 40 items runs with no stalls
        stall_left = ((results_seen / 40) % 3 == 1) ? 0 : $urandom_range(0, 11);
        if (!backlog_done && results_seen == 80) begin
          hold_left = BACKLOG;
          backlog_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: gives up when no item moves on either channel for too long.
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < WATCHDOG) begin
      @(posedge clk);
      if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle = 0;
      else idle++;
    end
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned k;
    int unsigned roll;
    bit          shrink;
    rst       = 1'b1;
    req.valid = 1'b0;
    req.cmd   = CMD_INSERT;
    req.value = '0;
    req.slot  = '0;
    rsp.ready = 1'b0;

    key_pool[0] = data_t'(32'h7FFF_FFFF);
    key_pool[1] = data_t'(32'h8000_0000);
    key_pool[2] = '0;
    key_pool[3] = data_t'(32'hFFFF_FFFF);
    key_pool[4] = data_t'($urandom);
    key_pool[5] = data_t'($urandom);

    // Directed: empty-list behavior first
    queue_command(CMD_DUMP,   data_t'($urandom), 7'd127);   // dump of empty list
    queue_command(CMD_SEARCH, '0, 7'd127);                   // search on empty list
    queue_command(CMD_DELETE, '0, 7'd1);                     // delete when empty
    queue_command(CMD_INSERT, key_pool[2], 7'd0);            // position zero
    queue_command(CMD_INSERT, key_pool[2], 7'd2);            // past end of empty list
    // build 0, max, max, min through head, middle and append inserts
    queue_command(CMD_INSERT, key_pool[0], 7'd1);
    queue_command(CMD_INSERT, key_pool[1], 7'd2);
    queue_command(CMD_INSERT, key_pool[2], 7'd1);
    queue_command(CMD_INSERT, key_pool[0], 7'd2);
    queue_command(CMD_INSERT, key_pool[3], 7'd127);          // bad position, top slot bit
    queue_command(CMD_INSERT, key_pool[3], 7'd6);            // two past the end
    queue_command(CMD_SEARCH, key_pool[0], 7'd0);            // two matches
    queue_command(CMD_SEARCH, key_pool[1], 7'd64);           // match at the tail
    queue_command(CMD_SEARCH, data_t'(32'h0001_2345), 7'd1); // no match
    queue_command(CMD_DUMP,   '0, 7'd0);
    queue_command(CMD_DELETE, key_pool[3], 7'd0);            // bad positions
    queue_command(CMD_DELETE, key_pool[3], 7'd5);
    queue_command(CMD_DELETE, key_pool[3], 7'd127);
    queue_command(CMD_DELETE, data_t'($urandom), 7'd2);      // middle; value ignored
    queue_command(CMD_DELETE, data_t'($urandom), 7'd3);      // tail
    queue_command(CMD_DELETE, '0, 7'd1);                     // head
    queue_command(CMD_DUMP,   data_t'($urandom), 7'd127);    // single entry
    queue_command(CMD_DELETE, '0, 7'd1);                     // back to empty
    queue_command(CMD_SEARCH, key_pool[3], 7'd127);
    queue_command(CMD_INSERT, key_pool[3], 7'd1);

    // Random: mostly well-formed commands, some raw noise, one run to full
    // and one drain to empty.
    shrink = 1'b0;
    for (k = 0; k < RAND_ITEMS; k++) begin
      if (k % 30 == 0) quiet = ($urandom_range(0, 2) == 0);
      if (k == 90) begin
        while (plan_len < DEPTH) queue_command(CMD_INSERT, pick_value(), live_slot(plan_len + 1));
        queue_command(CMD_INSERT, pick_value(), 7'd1);   // full
        queue_command(CMD_INSERT, pick_value(), 7'd0);   // full wins over bad position
        queue_command(CMD_SEARCH, key_pool[$urandom_range(0, 5)], 7'd0);
        queue_command(CMD_DUMP, '0, 7'd0);               // all 64 entries
        queue_command(CMD_DELETE, '0, 7'd64);            // last slot of a full list
        shrink = 1'b1;
      end
      if (k == 180) begin
        while (plan_len > 0) queue_command(CMD_DELETE, pick_value(), live_slot(plan_len));
        queue_command(CMD_DELETE, '0, 7'd0);             // empty wins over bad position
        queue_command(CMD_DUMP, '0, 7'd0);
        shrink = 1'b0;
      end
      roll = $urandom_range(0, 9);
      if (roll < 2) begin
        queue_command(cmd_t'($urandom_range(0, 3)), data_t'($urandom),
                      pos_t'($urandom_range(0, 127)));
      end else if (roll < (shrink ? 4 : 6)) begin
        if (plan_len < DEPTH) queue_command(CMD_INSERT, pick_value(), live_slot(plan_len + 1));
        else queue_command(CMD_SEARCH, pick_value(), pos_t'($urandom_range(0, 127)));
      end else if (roll < 8) begin
        if (plan_len > 0) queue_command(CMD_DELETE, data_t'($urandom), live_slot(plan_len));
        else queue_command(CMD_DELETE, data_t'($urandom), pos_t'($urandom_range(0, 127)));
      end else if (roll < 9) begin
        queue_command(CMD_SEARCH, pick_value(), pos_t'($urandom_range(0, 127)));
      end else begin
        queue_command(CMD_DUMP, data_t'($urandom), pos_t'($urandom_range(0, 127)));
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // sample on the falling edge so the checks never race the drivers
    while (command_q.size() != 0 || req.valid) @(negedge clk);
    while (expected_q.size() != 0) @(negedge clk);
    // anything extra shows up here
    repeat (TAIL) @(negedge clk);

    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

[filelist.f]
design/psl_pkg.sv
design/psl_req_if.sv
design/psl_rsp_if.sv
design/psl_cell.sv
design/positional_insert_delete_search_list.sv
sim/positional_insert_delete_search_list_test.sv
